[sv/rrtt_pkg.sv]
// Package for the request retry timeout table.
// Holds opcodes, event codes, table sizing and the entry record type.
package rrtt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int SLOT_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] OP_SEND = 3'd0;
  localparam logic [2:0] OP_RESPONSE = 3'd1;
  localparam logic [2:0] OP_CANCEL = 3'd2;
  localparam logic [2:0] OP_FLUSH = 3'd3;
  localparam logic [2:0] OP_TICK = 3'd4;

  localparam logic [3:0] EV_ACCEPTED = 4'd0;
  localparam logic [3:0] EV_BAD_ID = 4'd1;
  localparam logic [3:0] EV_FULL = 4'd2;
  localparam logic [3:0] EV_RESPONSE = 4'd3;
  localparam logic [3:0] EV_UNKNOWN = 4'd4;
  localparam logic [3:0] EV_CANCELLED = 4'd5;
  localparam logic [3:0] EV_RETRY = 4'd6;
  localparam logic [3:0] EV_TIMEOUT = 4'd7;
  localparam logic [3:0] EV_DONE = 4'd8;

  localparam logic CFG_INTERVAL = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  // One stored table entry; the valid bit lives in flip-flops.
  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  kind;
    logic        no_resend;
    logic [3:0]  retries;
    logic [31:0] sent_at;
  } entry_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] request_id;
    logic [7:0]  content_kind;
    logic        skip_resend;
    logic        response_error;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [31:0] result_id;
    logic [3:0]  slot;
    logic        error_relay;
    logic [4:0]  removed_count;
    logic        last;
  } rsp_t;

endpackage

[sv/rrtt_if.sv]
// Valid/ready channel interfaces for request and result words.
// The payload fields are declared directly; rrtt_pkg is not used here.
interface rrtt_req_if;
  logic valid;
  logic ready;
  logic [2:0] opcode;
  logic [31:0] request_id;
  logic [7:0] content_kind;
  logic skip_resend;
  logic response_error;
  logic [31:0] now_ms;
  modport source (output valid, opcode, request_id, content_kind, skip_resend,
                  response_error, now_ms, input ready);
  modport sink (input valid, opcode, request_id, content_kind, skip_resend,
                response_error, now_ms, output ready);
endinterface

interface rrtt_rsp_if;
  logic valid;
  logic ready;
  logic [3:0] event_res;
  logic [31:0] result_id;
  logic [3:0] slot;
  logic error_relay;
  logic [4:0] removed_count;
  logic last;
  modport source (output valid, event_res, result_id, slot, error_relay,
                  removed_count, last, input ready);
  modport sink (input valid, event_res, result_id, slot, error_relay,
                removed_count, last, output ready);
endinterface

[sv/rrtt_ram.sv]
// Single-port-write, single-read synchronous entry memory with a registered read.
// Depends on rrtt_pkg for the entry type and depth.
module rrtt_ram (
  input  logic                          clk,
  input  logic                          we,
  input  logic [rrtt_pkg::SLOT_W-1:0]   waddr,
  input  rrtt_pkg::entry_t              wdata,
  input  logic [rrtt_pkg::SLOT_W-1:0]   raddr,
  output rrtt_pkg::entry_t              rdata
);

  rrtt_pkg::entry_t mem [rrtt_pkg::TABLE_DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/request_retry_timeout_table_top.sv]
// Top level of the request retry timeout table.
// Depends on rrtt_pkg, rrtt_if and rrtt_ram.
//
// Usage: request words arrive on req (valid/ready); each word is an opcode
// with its id, kind, flags and the current time. Results leave on rsp, one
// word per event, with last set on the final word of a request. Send,
// response and cancel give one word, flush gives one, tick gives one per
// stale entry that times out or may be resent, and a closing done word.
// The entry table is one synchronous memory walked one slot per cycle while
// the output register is free: every valid request (opcodes 0 to 4) sweeps
// all TABLE_DEPTH slots, and the next request is accepted only once the
// closing word of the last one has been taken. Unused opcodes are dropped.
// A send or lookup finishes its sweep before writing the table.
// Results wait in an output register; while the receiver stalls, the sweep
// pauses on that slot. Reset clears all valid bits and restores the
// registers to an interval of 10000 ms and a limit of 5. Configuration is
// written through cfg_we/cfg_index/cfg_data, by the user only while idle; the block does not enforce this.
module request_retry_timeout_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  rrtt_req_if.sink    req,
  rrtt_rsp_if.source  rsp
);

  localparam int SW = rrtt_pkg::SLOT_W;
  localparam int CW = rrtt_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FIN   = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t state;
  rrtt_pkg::req_t cur;
  logic [15:0] interval;
  logic [3:0] limit;
  logic [rrtt_pkg::TABLE_DEPTH-1:0] valid_bits;
  logic [SW:0] rd_ptr;
  logic [SW-1:0] cmp_slot;
  logic cmp_live;
  logic found;
  logic [SW-1:0] found_slot;
  logic have_free;
  logic [SW-1:0] free_slot;
  logic [CW-1:0] removed;
  logic out_valid;
  rrtt_pkg::rsp_t out_word;

  logic ram_we;
  logic [SW-1:0] ram_waddr;
  rrtt_pkg::entry_t ram_wdata;
  logic [SW-1:0] ram_raddr;
  rrtt_pkg::entry_t ram_rdata;

  rrtt_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.event_res = out_word.event_res;
  assign rsp.result_id = out_word.result_id;
  assign rsp.slot = out_word.slot;
  assign rsp.error_relay = out_word.error_relay;
  assign rsp.removed_count = out_word.removed_count;
  assign rsp.last = out_word.last;

  // Per-slot evaluation of the entry that was read last cycle.
  logic [31:0] age;
  logic slot_valid, id_hit, stale, times_out, kind_hit, out_free;
  always_comb begin
    slot_valid = valid_bits[cmp_slot];
    id_hit = slot_valid && (ram_rdata.id == cur.request_id);
    kind_hit = slot_valid && (ram_rdata.kind == cur.content_kind);
    age = cur.now_ms - ram_rdata.sent_at;
    stale = slot_valid && (age > {16'd0, interval});
    times_out = stale && (ram_rdata.retries > limit);
    out_free = !out_valid || rsp.ready;
  end

  // A stalled sweep keeps reading the slot under comparison so its data holds.
  assign ram_raddr = (state == S_SCAN && cmp_live && !out_free) ? cmp_slot :
                     rd_ptr[SW-1:0];

  // Tick write-back of a retried entry, and the write of a newly sent entry.
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = cmp_slot;
    ram_wdata = ram_rdata;
    if (state == S_SCAN && cmp_live && cur.opcode == rrtt_pkg::OP_TICK &&
        stale && !times_out && out_free) begin
      ram_we = 1'b1;
      ram_wdata.retries = (ram_rdata.retries == 4'hF) ? 4'hF : ram_rdata.retries + 4'd1;
      ram_wdata.sent_at = cur.now_ms;
    end else if (state == S_FIN && cur.opcode == rrtt_pkg::OP_SEND &&
                 cur.request_id != 32'd0 && !found && have_free) begin
      ram_we = 1'b1;
      ram_waddr = free_slot;
      ram_wdata.id = cur.request_id;
      ram_wdata.kind = cur.content_kind;
      ram_wdata.no_resend = cur.skip_resend;
      ram_wdata.retries = 4'd0;
      ram_wdata.sent_at = cur.now_ms;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= 16'd10000;
      limit <= 4'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrtt_pkg::CFG_INTERVAL: interval <= cfg_data;
        rrtt_pkg::CFG_LIMIT: limit <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Sequencer: one slot compared per cycle while the output register is free, results through the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid_bits <= '0;
      out_valid <= 1'b0;
      rd_ptr <= '0;
      cmp_live <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur <= '{req.opcode, req.request_id, req.content_kind, req.skip_resend,
                     req.response_error, req.now_ms};
            rd_ptr <= '0;
            cmp_live <= 1'b0;
            found <= 1'b0;
            have_free <= 1'b0;
            removed <= '0;
            if (req.opcode <= rrtt_pkg::OP_TICK) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!cmp_live || out_free) begin
            if (cmp_live) begin
              case (cur.opcode)
                rrtt_pkg::OP_SEND, rrtt_pkg::OP_RESPONSE, rrtt_pkg::OP_CANCEL: begin
                  if (id_hit && !found) begin
                    found <= 1'b1;
                    found_slot <= cmp_slot;
                  end
                  if (!slot_valid && !have_free) begin
                    have_free <= 1'b1;
                    free_slot <= cmp_slot;
                  end
                end
                rrtt_pkg::OP_FLUSH: begin
                  if (kind_hit) begin
                    valid_bits[cmp_slot] <= 1'b0;
                    removed <= removed + CW'(1);
                  end
                end
                default: begin
                  if (times_out) begin
                    valid_bits[cmp_slot] <= 1'b0;
                    removed <= removed + CW'(1);
                    out_valid <= 1'b1;
                    out_word <= '{rrtt_pkg::EV_TIMEOUT, ram_rdata.id, 4'(cmp_slot),
                                  1'b0, 5'd0, 1'b0};
                  end else if (stale && !ram_rdata.no_resend) begin
                    out_valid <= 1'b1;
                    out_word <= '{rrtt_pkg::EV_RETRY, ram_rdata.id, 4'(cmp_slot),
                                  1'b0, 5'd0, 1'b0};
                  end
                end
              endcase
            end
            if (rd_ptr == (SW+1)'(rrtt_pkg::TABLE_DEPTH)) begin
              cmp_live <= 1'b0;
              state <= S_FIN;
            end else begin
              cmp_slot <= rd_ptr[SW-1:0];
              cmp_live <= 1'b1;
              rd_ptr <= rd_ptr + (SW+1)'(1);
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state <= S_OUT;
            case (cur.opcode)
              rrtt_pkg::OP_SEND: begin
                if (cur.request_id == 32'd0 || found) begin
                  out_word <= '{rrtt_pkg::EV_BAD_ID, cur.request_id, 4'd0, 1'b0, 5'd0, 1'b1};
                end else if (!have_free) begin
                  out_word <= '{rrtt_pkg::EV_FULL, cur.request_id, 4'd0, 1'b0, 5'd0, 1'b1};
                end else begin
                  valid_bits[free_slot] <= 1'b1;
                  out_word <= '{rrtt_pkg::EV_ACCEPTED, cur.request_id, 4'(free_slot),
                                1'b0, 5'd0, 1'b1};
                end
              end
              rrtt_pkg::OP_RESPONSE, rrtt_pkg::OP_CANCEL: begin
                if (!found) begin
                  out_word <= '{rrtt_pkg::EV_UNKNOWN, cur.request_id, 4'd0, 1'b0, 5'd0, 1'b1};
                end else begin
                  valid_bits[found_slot] <= 1'b0;
                  out_word <= '{(cur.opcode == rrtt_pkg::OP_RESPONSE) ?
                                rrtt_pkg::EV_RESPONSE : rrtt_pkg::EV_CANCELLED,
                                cur.request_id, 4'(found_slot),
                                (cur.opcode == rrtt_pkg::OP_RESPONSE) &
                                cur.response_error, 5'd0, 1'b1};
                end
              end
              default: begin
                out_word <= '{rrtt_pkg::EV_DONE, 32'd0, 4'd0, 1'b0, 5'(removed), 1'b1};
              end
            endcase
          end
        end
        S_OUT: begin
          // Wait for the last word to drain so the next request sees a settled table.
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer.
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> (state == S_IDLE)) else $error("ready outside idle");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("result dropped");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.event_res == rrtt_pkg::EV_DONE) |-> rsp.last)
    else $error("done without last");
  a_scan_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.event_res == rrtt_pkg::EV_RETRY ||
     rsp.event_res == rrtt_pkg::EV_TIMEOUT)) |-> !rsp.last)
    else $error("tick word marked last");

endmodule

[bench/request_retry_timeout_table_top_tb.sv]
// Testbench for the request retry timeout table top level.
// Depends on rrtt_pkg and the rrtt_req_if/rrtt_rsp_if interfaces; self-checking.
module request_retry_timeout_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rrtt_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_INTERVAL;
  logic [15:0] cfg_data = '0;
  bit failed = 1'b0;

  rrtt_req_if req();
  rrtt_rsp_if rsp();

  request_retry_timeout_table_top u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
  );

  always #5 clk = ~clk;

  // Shadow copy of the table and the registers.
  logic        tbl_valid [TABLE_DEPTH];
  logic [31:0] tbl_id [TABLE_DEPTH];
  logic [7:0]  tbl_kind [TABLE_DEPTH];
  logic        tbl_nr [TABLE_DEPTH];
  logic [3:0]  tbl_retries [TABLE_DEPTH];
  logic [31:0] tbl_sent [TABLE_DEPTH];
  logic [15:0] interval_ms = 16'd10000;
  logic [3:0]  limit = 4'd5;
  logic [31:0] clock_ms = 0;
  rsp_t expected_events [$];

  function automatic rsp_t make_event(logic [3:0] ev, logic [31:0] id, int s,
                                      logic err, int cnt, logic lst);
    rsp_t r;
    r.event_res = ev; r.result_id = id; r.slot = s[3:0];
    r.error_relay = err; r.removed_count = cnt[4:0]; r.last = lst;
    return r;
  endfunction

  function automatic int lookup_slot(logic [31:0] id);
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (tbl_valid[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  // Apply one request word to the shadow table and queue its events.
  function automatic void track_request(req_t w);
    int s;
    int removed;
    logic [31:0] age;
    s = -1;
    removed = 0;
    case (w.opcode)
      OP_SEND: begin
        if (w.request_id == 0 || lookup_slot(w.request_id) >= 0) begin
          expected_events.push_back(make_event(EV_BAD_ID, w.request_id, 0, 0, 0, 1));
        end else begin
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (!tbl_valid[i] && s < 0) s = i;
          if (s < 0) begin
            expected_events.push_back(make_event(EV_FULL, w.request_id, 0, 0, 0, 1));
          end else begin
            tbl_valid[s] = 1; tbl_id[s] = w.request_id; tbl_kind[s] = w.content_kind;
            tbl_nr[s] = w.skip_resend; tbl_retries[s] = 0; tbl_sent[s] = w.now_ms;
            expected_events.push_back(make_event(EV_ACCEPTED, w.request_id, s, 0, 0, 1));
          end
        end
      end
      OP_RESPONSE, OP_CANCEL: begin
        s = lookup_slot(w.request_id);
        if (s < 0) begin
          expected_events.push_back(make_event(EV_UNKNOWN, w.request_id, 0, 0, 0, 1));
        end else begin
          tbl_valid[s] = 0;
          if (w.opcode == OP_RESPONSE)
            expected_events.push_back(make_event(EV_RESPONSE, w.request_id, s,
                                                 w.response_error, 0, 1));
          else
            expected_events.push_back(make_event(EV_CANCELLED, w.request_id, s, 0, 0, 1));
        end
      end
      OP_FLUSH: begin
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (tbl_valid[i] && tbl_kind[i] == w.content_kind) begin
            tbl_valid[i] = 0;
            removed++;
          end
        expected_events.push_back(make_event(EV_DONE, 0, 0, 0, removed, 1));
      end
      OP_TICK: begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (tbl_valid[i]) begin
            age = w.now_ms - tbl_sent[i];
            if (age > {16'd0, interval_ms}) begin
              if (tbl_retries[i] > limit) begin
                tbl_valid[i] = 0;
                removed++;
                expected_events.push_back(make_event(EV_TIMEOUT, tbl_id[i], i, 0, 0, 0));
              end else begin
                if (!tbl_nr[i])
                  expected_events.push_back(make_event(EV_RETRY, tbl_id[i], i, 0, 0, 0));
                if (tbl_retries[i] != 4'd15) tbl_retries[i]++;
                tbl_sent[i] = w.now_ms;
              end
            end
          end
        end
        expected_events.push_back(make_event(EV_DONE, 0, 0, 0, removed, 1));
      end
      default: ;
    endcase
  endfunction

  // Send one request word with a random gap before it.
  task automatic send_word(logic [2:0] op, logic [31:0] id, logic [7:0] kind,
                           logic nr, logic err, logic [31:0] now);
    req_t w;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    w.opcode = op; w.request_id = id; w.content_kind = kind;
    w.skip_resend = nr; w.response_error = err; w.now_ms = now;
    req.valid <= 1'b1; req.opcode <= op; req.request_id <= id;
    req.content_kind <= kind; req.skip_resend <= nr; req.response_error <= err;
    req.now_ms <= now;
    do @(posedge clk); while (!req.ready);
    track_request(w);
    @(negedge clk);
  endtask

  // Wait until every expected word has come, then let the sweep settle.
  task automatic drain();
    req.valid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    req.valid <= 1'b0;
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_INTERVAL) interval_ms = val; else limit = val[3:0];
  endtask

  // Result checker with a randomly stalling receiver.
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_events.size() == 0) begin
        $error("unexpected result word event_res=%0d", rsp.event_res);
        failed = 1'b1;
      end else begin
        rsp_t e;
        e = expected_events.pop_front();
        if (rsp.event_res !== e.event_res) begin
          $error("event_res expected %0d actual %0d", e.event_res, rsp.event_res);
          failed = 1'b1;
        end
        if (rsp.result_id !== e.result_id) begin
          $error("result_id expected %0h actual %0h", e.result_id, rsp.result_id);
          failed = 1'b1;
        end
        if (rsp.slot !== e.slot) begin
          $error("slot expected %0d actual %0d", e.slot, rsp.slot);
          failed = 1'b1;
        end
        if (rsp.error_relay !== e.error_relay) begin
          $error("error_relay expected %0b actual %0b", e.error_relay, rsp.error_relay);
          failed = 1'b1;
        end
        if (rsp.removed_count !== e.removed_count) begin
          $error("removed_count expected %0d actual %0d", e.removed_count,
                 rsp.removed_count);
          failed = 1'b1;
        end
        if (rsp.last !== e.last) begin
          $error("last expected %0b actual %0b", e.last, rsp.last);
          failed = 1'b1;
        end
      end
    end
  end

  // Receiver readiness changes at the falling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp.ready <= 1'b0;
    end else if (rsp.valid && rsp.ready) begin
      stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
      rsp.ready <= 1'b1;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Directed: every opcode, bad ids, full table, no-resend, ignored opcodes.
  task automatic test_directed();
    send_word(OP_SEND, 32'h0, 8'h00, 0, 0, 0);
    send_word(OP_SEND, 32'hFFFF_FFFF, 8'hFF, 1, 0, 32'hFFFF_FFF0);
    send_word(OP_SEND, 32'hFFFF_FFFF, 8'h01, 0, 0, 0);
    for (int i = 1; i <= 15; i++) send_word(OP_SEND, i, i[7:0] & 8'h3, 0, 0, 32'd100);
    send_word(OP_SEND, 32'd99, 8'h00, 0, 0, 0);
    send_word(OP_RESPONSE, 32'd1, 0, 0, 1, 0);
    send_word(OP_RESPONSE, 32'd1, 0, 0, 0, 0);
    send_word(OP_CANCEL, 32'd2, 0, 0, 0, 0);
    send_word(3'd5, 32'd3, 0, 0, 0, 0);
    send_word(3'd7, 32'd3, 0, 1, 1, 32'hFFFF_FFFF);
    send_word(OP_TICK, 0, 0, 0, 0, 32'd20000);
    send_word(OP_TICK, 0, 0, 0, 0, 32'd20050);
    send_word(OP_FLUSH, 0, 8'h03, 0, 0, 0);
    send_word(OP_FLUSH, 0, 8'hFF, 0, 0, 0);
    drain();
  endtask

  // Saturating retries with large limits and the smallest interval, then the largest interval with the smallest limit.
  task automatic test_saturation();
    write_reg(CFG_LIMIT, 16'd14);
    write_reg(CFG_INTERVAL, 16'd0);
    send_word(OP_SEND, 32'h8000_0000, 8'h10, 1, 0, 32'd0);
    for (int t = 1; t <= 20; t++) send_word(OP_TICK, 0, 0, 0, 0, t);
    drain();
    write_reg(CFG_LIMIT, 16'hF);
    send_word(OP_SEND, 32'h8000_0001, 8'h10, 0, 0, 32'd0);
    for (int t = 1; t <= 19; t++) send_word(OP_TICK, 0, 0, 0, 0, 32'd100 + t);
    send_word(OP_FLUSH, 0, 8'h10, 0, 0, 0);
    drain();
    write_reg(CFG_INTERVAL, 16'hFFFF);
    write_reg(CFG_LIMIT, 16'd0);
    send_word(OP_SEND, 32'h55, 8'h20, 0, 0, 32'hFFFF_0000);
    send_word(OP_TICK, 0, 0, 0, 0, 32'hFFFF_0000 + 32'hFFFF);
    send_word(OP_TICK, 0, 0, 0, 0, 32'd0);
    send_word(OP_TICK, 0, 0, 0, 0, 32'd70000);
    send_word(OP_TICK, 0, 0, 0, 0, 32'd140000);
    drain();
  endtask

  // Random traffic over several register settings, mostly well-formed.
  task automatic test_random();
    logic [31:0] ids [$];
    logic [31:0] id;
    int op;
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(CFG_INTERVAL, phase == 3 ? 16'd10000 : 16'($urandom_range(0, 400)));
      write_reg(CFG_LIMIT, 16'($urandom_range(0, 14)));
      for (int n = 0; n < 47; n++) begin
        op = $urandom_range(0, 99);
        clock_ms += $urandom_range(0, 150);
        if (phase == 3 && $urandom_range(0, 3) == 0) clock_ms = $urandom;
        if (op < 35) begin
          id = ($urandom_range(0, 9) == 0 && ids.size() != 0) ?
               ids[$urandom_range(0, ids.size() - 1)] :
               ($urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 40)));
          send_word(OP_SEND, id, 8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3)),
                    1'($urandom), 1'($urandom), clock_ms);
          ids.push_back(id);
        end else if (op < 60) begin
          id = (ids.size() != 0 && $urandom_range(0, 4) != 0) ?
               ids[$urandom_range(0, ids.size() - 1)] : $urandom;
          send_word(op < 48 ? OP_RESPONSE : OP_CANCEL, id, 8'($urandom), 1'($urandom),
                    1'($urandom), clock_ms);
        end else if (op < 65) begin
          send_word(OP_FLUSH, $urandom, 8'($urandom_range(0, 3)), 1'($urandom),
                    1'($urandom), clock_ms);
        end else if (op < 97) begin
          send_word(OP_TICK, $urandom, 8'($urandom), 1'($urandom), 1'($urandom), clock_ms);
        end else begin
          send_word(3'($urandom_range(5, 7)), $urandom, 8'($urandom), 1'($urandom),
                    1'($urandom), $urandom);
        end
        if (ids.size() > 40) ids.delete(0);
      end
      drain();
    end
  endtask

  initial begin
    req.valid = 1'b0; req.opcode = OP_SEND; req.request_id = '0;
    req.content_kind = '0; req.skip_resend = 1'b0; req.response_error = 1'b0;
    req.now_ms = '0; rsp.ready = 1'b1;
    for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);
    test_directed();
    test_saturation();
    test_random();
    if (!failed) begin
      $display("request_retry_timeout_table_top test passed");
    end else begin
      $display("request_retry_timeout_table_top test failed");
    end
    $finish;
  end

  // Run limit well above the slowest correct run.
  initial begin
    #20ms;
    $display("request_retry_timeout_table_top test failed");
    $finish;
  end
endmodule
